// ===== rtl/bft_pkg.sv =====
// Package: shared types, constants and codes for the flow tracker.
`timescale 1ns / 1ps
package bft_pkg;
  localparam int DefBuckets = 16;
  localparam int DefWays = 4;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [2:0] KIND_DROP = 3'd0;
  localparam logic [2:0] KIND_UNCL = 3'd1;
  localparam logic [2:0] KIND_CLS = 3'd2;
  localparam logic [2:0] KIND_FULL = 3'd3;
  localparam logic [2:0] KIND_EXPORT = 3'd4;
  localparam logic [2:0] KIND_DONE = 3'd5;
  localparam logic [1:0] REG_FIN = 2'd0;
  localparam logic [1:0] REG_IDLE = 2'd1;
  localparam logic [1:0] REG_UDP = 2'd2;
  localparam logic [1:0] REG_TCP = 2'd3;
  localparam int MaxExports = 63;

  typedef struct packed {
    logic [31:0] low_addr;
    logic [31:0] high_addr;
    logic [31:0] ports;
    logic [7:0] proto;
    logic fin_seen;
    logic classified;
    logic [15:0] app;
    logic [31:0] begin_sec;
    logic [31:0] end_sec;
    logic [31:0] bytes;
    logic [31:0] packets;
  } slot_t;

  typedef struct packed {
    logic [15:0] fin_hold;
    logic [15:0] idle_timeout;
    logic [7:0] udp_limit;
    logic [7:0] tcp_limit;
  } cfg_t;
endpackage

// ===== rtl/bidirectional_flow_tracker.sv =====
// Top level: flow table sequencer with one slot read port walked way by way.
// Busy is high from a packet's accepting edge until its result strobes, so a new packet
// is not taken before the last one's result.
// A scan tick reads the BUCKETS*WAYS slots in turn, stopping early once MaxExports flows
// are exported, then strobes the done word. Results are strobed one cycle; no stall.
// Synchronous reset clears all flows and restores register defaults.
`timescale 1ns / 1ps
module bidirectional_flow_tracker import bft_pkg::*; #(
  parameter int BUCKETS = DefBuckets,
  parameter int WAYS = DefWays
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic command,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0] ip_proto,
  input  logic [15:0] payload_len,
  input  logic [7:0] tcp_flags,
  input  logic [15:0] app_id,
  input  logic [31:0] now_sec,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic strobe,
  output logic [2:0] kind,
  output logic [31:0] low_addr,
  output logic [31:0] high_addr,
  output logic [15:0] low_port,
  output logic [15:0] high_port,
  output logic [7:0] flow_proto,
  output logic [15:0] flow_app,
  output logic [31:0] begin_sec,
  output logic [31:0] end_sec,
  output logic [31:0] byte_count,
  output logic [31:0] packet_count,
  output logic last
);
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int AW = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1;
  localparam int BW = $clog2(BUCKETS) > 0 ? $clog2(BUCKETS) : 1;
  localparam int WW = $clog2(WAYS) > 0 ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HASH = 4'd1;
  localparam logic [3:0] S_PROBE = 4'd2;
  localparam logic [3:0] S_WAIT = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SCANRD = 4'd5;
  localparam logic [3:0] S_SCANWT = 4'd6;
  localparam logic [3:0] S_SCANCK = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  cfg_t cfg;
  bft_cfg u_cfg (.clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg);

  logic [3:0] state;
  logic [AW-1:0] rd_addr;
  slot_t rd_data;
  logic rd_live;
  logic wr_en, set_live, exp_en;
  logic [AW-1:0] wr_addr, exp_addr;
  slot_t wr_data;
  bft_store #(.SLOTS(SLOTS), .AW(AW)) u_store (
    .clk, .rst, .rd_addr, .rd_data, .rd_live, .wr_en, .wr_addr, .wr_data,
    .set_live, .exp_en, .exp_addr
  );

  // latched packet
  logic is_tcp, is_udp, fin;
  logic [31:0] la, ha, pkt_now;
  logic [15:0] lp, hp, len, app;
  logic [7:0] pr, flags;
  logic [BW-1:0] bucket;
  logic [WW:0] way;
  logic [WW-1:0] hit_way, free_way;
  logic hit, has_free;
  logic [CW-1:0] scan_idx;
  logic [5:0] nexp;

  // canonical order of incoming packet
  logic in_tcp, in_udp, swap;
  logic [15:0] isp, idp;
  always_comb begin
    in_tcp = ip_proto == PROTO_TCP;
    in_udp = ip_proto == PROTO_UDP;
    isp = (in_tcp || in_udp) ? src_port : 16'd0;
    idp = (in_tcp || in_udp) ? dst_port : 16'd0;
    swap = src_addr > dst_addr;
  end

  logic [WW-1:0] cur_way;
  assign cur_way = way[WW-1:0] - 1'b1;
  logic key_eq;
  assign key_eq = rd_data.low_addr == la && rd_data.high_addr == ha &&
                  rd_data.ports == {lp, hp} && rd_data.proto == pr;

  logic [31:0] sum;
  assign sum = la + ha + {16'd0, lp} + {16'd0, hp} + {24'd0, pr};

  // update path for the decide step
  slot_t upd;
  logic [31:0] bsum, pk;
  logic clsn, giveup;
  logic [2:0] upd_kind;
  always_comb begin
    upd = rd_data;
    if (!hit) begin
      upd = '0;
      upd.low_addr = la;
      upd.high_addr = ha;
      upd.ports = {lp, hp};
      upd.proto = pr;
      upd.fin_seen = fin;
      upd.begin_sec = pkt_now;
      upd.bytes = {16'd0, len};
    end else begin
      if (fin) upd.fin_seen = 1'b1;
      bsum = rd_data.bytes + {16'd0, len};
      upd.bytes = (bsum < rd_data.bytes) ? 32'hFFFF_FFFF : bsum;
    end
    bsum = rd_data.bytes + {16'd0, len};
    upd.end_sec = pkt_now;
    pk = upd.packets;
    if (pk != 32'hFFFF_FFFF) pk = pk + 1'b1;
    upd.packets = pk;
    giveup = 1'b0;
    clsn = 1'b0;
    if (upd.classified) begin
      upd_kind = KIND_CLS;
    end else begin
      upd.app = app;
      clsn = app != 16'd0 || (is_udp && pk > {24'd0, cfg.udp_limit}) ||
             (is_tcp && pk > {24'd0, cfg.tcp_limit});
      upd.classified = clsn;
      giveup = clsn && app == 16'd0;
      upd_kind = (clsn && !giveup) ? KIND_CLS : KIND_UNCL;
    end
  end

  logic drop;
  assign drop = is_tcp && (!flags[1] || flags[4]);

  // scan check
  logic [31:0] idle, limit;
  logic timed_out;
  always_comb begin
    idle = (pkt_now >= rd_data.end_sec) ? pkt_now - rd_data.end_sec : 32'd0;
    limit = (rd_data.proto == PROTO_TCP && rd_data.classified && rd_data.fin_seen) ?
            {16'd0, cfg.fin_hold} : {16'd0, cfg.idle_timeout};
    timed_out = rd_live && idle >= limit;
  end

  assign busy = state != S_IDLE;

  always_comb begin
    wr_en = 1'b0;
    set_live = 1'b0;
    exp_en = 1'b0;
    wr_addr = AW'(bucket) * AW'(WAYS) + AW'(hit ? hit_way : free_way);
    exp_addr = wr_addr;
    wr_data = upd;
    if (state == S_DECIDE && (hit || (!drop && has_free))) begin
      wr_en = 1'b1;
      set_live = !hit;
      exp_en = giveup;
    end
    if (state == S_SCANCK && timed_out && nexp != 6'(MaxExports)) begin
      exp_en = 1'b1;
      exp_addr = AW'(scan_idx - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    last <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          pkt_now <= now_sec;
          if (command) begin
            scan_idx <= '0;
            nexp <= '0;
            state <= S_SCANRD;
          end else begin
            is_tcp <= in_tcp;
            is_udp <= in_udp;
            fin <= in_tcp && tcp_flags[0];
            flags <= tcp_flags;
            pr <= ip_proto;
            len <= (in_tcp || in_udp) ? payload_len : 16'd0;
            app <= app_id;
            la <= swap ? dst_addr : src_addr;
            ha <= swap ? src_addr : dst_addr;
            lp <= swap ? idp : isp;
            hp <= swap ? isp : idp;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          bucket <= BW'(sum % BUCKETS);
          rd_addr <= AW'(AW'(sum % BUCKETS) * AW'(WAYS));
          way <= '0;
          hit <= 1'b0;
          has_free <= 1'b0;
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (way != '0) begin
            if (!rd_live) begin
              if (!has_free) free_way <= cur_way;
              has_free <= 1'b1;
            end else if (!hit && key_eq) begin
              hit <= 1'b1;
              hit_way <= cur_way;
            end
          end
          if (way == (WW+1)'(WAYS)) begin
            if (rd_live && !hit && key_eq)
              rd_addr <= AW'(bucket) * AW'(WAYS) + AW'(cur_way);
            else
              rd_addr <= AW'(bucket) * AW'(WAYS) + AW'(hit_way);
            state <= S_WAIT;
          end else begin
            rd_addr <= AW'(bucket) * AW'(WAYS) + AW'(way + 1'b1);
            way <= way + 1'b1;
          end
        end
        S_WAIT: state <= S_DECIDE;
        S_DECIDE: begin
          strobe <= 1'b1;
          last <= 1'b1;
          state <= S_IDLE;
          if (!hit && (drop || !has_free)) begin
            kind <= drop ? KIND_DROP : KIND_FULL;
            low_addr <= la; high_addr <= ha; low_port <= lp; high_port <= hp;
            flow_proto <= pr; flow_app <= '0; begin_sec <= '0; end_sec <= '0;
            byte_count <= '0; packet_count <= '0;
          end else begin
            kind <= upd_kind;
            low_addr <= upd.low_addr; high_addr <= upd.high_addr;
            low_port <= upd.ports[31:16]; high_port <= upd.ports[15:0];
            flow_proto <= upd.proto; flow_app <= upd.app;
            begin_sec <= upd.begin_sec; end_sec <= upd.end_sec;
            byte_count <= upd.bytes; packet_count <= upd.packets;
          end
        end
        S_SCANRD: begin
          if (scan_idx == CW'(SLOTS) || nexp == 6'(MaxExports)) begin
            state <= S_DONE;
          end else begin
            rd_addr <= AW'(scan_idx);
            scan_idx <= scan_idx + 1'b1;
            state <= S_SCANWT;
          end
        end
        S_SCANWT: state <= S_SCANCK;
        S_SCANCK: begin
          state <= S_SCANRD;
          if (timed_out && rd_data.classified) begin
            nexp <= nexp + 1'b1;
            strobe <= 1'b1;
            kind <= KIND_EXPORT;
            low_addr <= rd_data.low_addr; high_addr <= rd_data.high_addr;
            low_port <= rd_data.ports[31:16]; high_port <= rd_data.ports[15:0];
            flow_proto <= rd_data.proto; flow_app <= rd_data.app;
            begin_sec <= rd_data.begin_sec; end_sec <= rd_data.end_sec;
            byte_count <= rd_data.bytes; packet_count <= rd_data.packets;
          end
        end
        S_DONE: begin
          strobe <= 1'b1;
          last <= 1'b1;
          kind <= KIND_DONE;
          low_addr <= '0; high_addr <= '0; low_port <= '0; high_port <= '0;
          flow_proto <= '0; flow_app <= '0; begin_sec <= '0; end_sec <= '0;
          byte_count <= '0; packet_count <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_last_strobe;
    @(posedge clk) disable iff (rst) last |-> strobe;
  endproperty
  assert property (p_last_strobe) else $error("last without strobe");

  property p_start_idle;
    @(posedge clk) disable iff (rst) (start && !busy) |=> busy;
  endproperty
  assert property (p_start_idle) else $error("accepted item did not go busy");

  property p_done_last;
    @(posedge clk) disable iff (rst) (strobe && kind == KIND_DONE) |-> last;
  endproperty
  assert property (p_done_last) else $error("scan done without last");
endmodule

// ===== rtl/bft_cfg.sv =====
// Configuration register file.
`timescale 1ns / 1ps
module bft_cfg import bft_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t cfg
);
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{16'd40, 16'd101, 8'd8, 8'd10};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIN: cfg.fin_hold <= cfg_data;
        REG_IDLE: cfg.idle_timeout <= cfg_data;
        REG_UDP: cfg.udp_limit <= cfg_data[7:0];
        REG_TCP: cfg.tcp_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/bft_store.sv =====
// Slot memory with registered read and per-slot valid and expired flags.
`timescale 1ns / 1ps
module bft_store import bft_pkg::*; #(
  parameter int SLOTS = DefBuckets * DefWays,
  parameter int AW = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic [AW-1:0] rd_addr,
  output slot_t rd_data,
  output logic rd_live,
  input  logic wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t wr_data,
  input  logic set_live,
  input  logic exp_en,
  input  logic [AW-1:0] exp_addr
);
  slot_t mem [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] expired;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      expired <= '0;
      rd_live <= 1'b0;
    end else begin
      rd_live <= valid[rd_addr] && !expired[rd_addr] &&
                 !(exp_en && exp_addr == rd_addr);
      if (set_live) valid[wr_addr] <= 1'b1;
      if (exp_en) expired[exp_addr] <= 1'b1;
      else if (set_live) expired[wr_addr] <= 1'b0;
    end
  end
endmodule
